/* rtl/bbc_pkg.sv */
`default_nettype none

package bbc_pkg;

	// Brightness ceiling and the scroll lock bit of the host indicator byte
	localparam logic [6:0] LEVEL_MAX   = 7'd100;
	localparam int         SCROLL_BIT  = 2;

	// Command and event codes
	typedef enum logic [3:0] {
		ACT_ON       = 4'd0,
		ACT_OFF      = 4'd1,
		ACT_TOGGLE   = 4'd2,
		ACT_SET      = 4'd3,
		ACT_UP       = 4'd4,
		ACT_DOWN     = 4'd5,
		ACT_CYCLE    = 4'd6,
		ACT_ACTIVITY = 4'd7,
		ACT_USB      = 4'd8,
		ACT_INDICATE = 4'd9,
		ACT_RESTORE  = 4'd10
	} action_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
	localparam logic [1:0] CFG_IDLE_EN   = 2'd1;
	localparam logic [1:0] CFG_USB_EN    = 2'd2;
	localparam logic [1:0] CFG_DPMS_EN   = 2'd3;

	typedef struct packed {
		logic [6:0] step_size;
		logic       idle_en;
		logic       usb_en;
		logic       dpms_en;
	} cfg_t;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] level;
		logic       condition;
		logic [7:0] indicators;
	} item_t;

	typedef struct packed {
		logic [6:0] led_level;
		logic [6:0] reported_level;
		logic       is_on;
		logic       save_request;
		logic       status;
	} result_t;

	typedef struct packed {
		logic [6:0] level;
		logic       on;
		logic       idle_flag;
		logic       usb_flag;
		logic       suppressed;
	} state_t;

	// Saturate an 8-bit value to the brightness ceiling
	function automatic logic [6:0] sat_level(input logic [7:0] v);
		sat_level = (v > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : v[6:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/bbc_cfg_regs.sv */
`default_nettype none

module bbc_cfg_regs
	import bbc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire logic [1:0] wr_index,
	input  wire logic [6:0] wr_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	// Register file, written one register per configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size <= 7'd20;
			cfg_q.idle_en   <= 1'b0;
			cfg_q.usb_en    <= 1'b0;
			cfg_q.dpms_en   <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_STEP_SIZE: cfg_q.step_size <= wr_data;
				CFG_IDLE_EN:   cfg_q.idle_en   <= wr_data[0];
				CFG_USB_EN:    cfg_q.usb_en    <= wr_data[0];
				CFG_DPMS_EN:   cfg_q.dpms_en   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/bbc_core.sv */
`default_nettype none

module bbc_core
	import bbc_pkg::*;
#(
	parameter logic [6:0] START_LEVEL = 7'd40,
	parameter logic       START_ON_B  = 1'b1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step_en,
	input  item_t     item,
	input  cfg_t      cfg,
	output result_t   result
);

	state_t     state_q;
	state_t     nxt;
	logic [6:0] step;
	logic [7:0] sum;
	logic       save;
	logic       status;
	logic [6:0] rep;

	assign step = (cfg.step_size > LEVEL_MAX) ? LEVEL_MAX : cfg.step_size;
	assign sum  = {1'b0, state_q.level} + {1'b0, step};

	// Next state for the item in the input register
	always_comb begin
		nxt    = state_q;
		save   = 1'b0;
		status = 1'b0;
		case (item.action)
			ACT_ON: begin
				if (state_q.level < step) nxt.level = step;
				nxt.on = 1'b1;
				save   = 1'b1;
			end
			ACT_OFF: begin
				nxt.on = 1'b0;
				save   = 1'b1;
			end
			ACT_TOGGLE: begin
				if (state_q.on) begin
					nxt.on = 1'b0;
				end else begin
					if (state_q.level < step) nxt.level = step;
					nxt.on = 1'b1;
				end
				save = 1'b1;
			end
			ACT_SET: begin
				nxt.level = sat_level(item.level);
				nxt.on    = (nxt.level != 7'd0);
				save      = 1'b1;
			end
			ACT_UP: begin
				nxt.level = sat_level(sum);
				nxt.on    = (nxt.level != 7'd0);
				save      = 1'b1;
			end
			ACT_DOWN: begin
				nxt.level = (state_q.level > step) ? (state_q.level - step) : 7'd0;
				nxt.on    = (nxt.level != 7'd0);
				save      = 1'b1;
			end
			ACT_CYCLE: begin
				nxt.level = (state_q.level == LEVEL_MAX) ? 7'd0 : sat_level(sum);
				nxt.on    = (nxt.level != 7'd0);
				save      = 1'b1;
			end
			ACT_ACTIVITY: begin
				// auto-off rule: act only when the light disagrees with the condition
				if (!cfg.idle_en) begin
					status = 1'b1;
				end else if (state_q.on != item.condition) begin
					nxt.on        = item.condition & state_q.idle_flag;
					nxt.idle_flag = !item.condition;
				end
			end
			ACT_USB: begin
				if (!cfg.usb_en) begin
					status = 1'b1;
				end else if (state_q.on != item.condition) begin
					nxt.on       = item.condition & state_q.usb_flag;
					nxt.usb_flag = !item.condition;
				end
			end
			ACT_INDICATE: begin
				if (cfg.dpms_en) nxt.suppressed = item.indicators[SCROLL_BIT];
				else             status = 1'b1;
			end
			ACT_RESTORE: begin
				nxt.level = sat_level(item.level);
				nxt.on    = item.condition;
			end
			default: status = 1'b1;
		endcase
	end

	// Result as seen after the item
	assign rep = nxt.on ? nxt.level : 7'd0;

	always_comb begin
		result.led_level      = (nxt.suppressed && cfg.dpms_en) ? 7'd0 : rep;
		result.reported_level = rep;
		result.is_on          = nxt.on;
		result.save_request   = save;
		result.status         = status;
	end

	// Stored state, updated once per item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.level      <= START_LEVEL;
			state_q.on         <= START_ON_B;
			state_q.idle_flag  <= 1'b0;
			state_q.usb_flag   <= 1'b0;
			state_q.suppressed <= 1'b0;
		end else if (step_en) begin
			state_q <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/backlight_brightness_controller.sv */
// Path: item in the input register, then its result in the result register;
// a result that is not taken holds back the item behind it.
// Throughput: one item per cycle unless out_ready stalls; one state update per item.
// Reset (arst_n low, asynchronous): pipeline empty, brightness START_BRIGHTNESS,
// on flag START_ON, restore and suppression flags clear, registers at reset values.
// Configuration writes are taken in any cycle.
`default_nettype none

module backlight_brightness_controller
	import bbc_pkg::*;
#(
	parameter int START_BRIGHTNESS = 40,
	parameter int START_ON         = 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [3:0] action,
	input  wire logic [7:0] level,
	input  wire logic       condition,
	input  wire logic [7:0] indicators,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      led_level,
	output logic [6:0]      reported_level,
	output logic            is_on,
	output logic            save_request,
	output logic            status,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	assign cfg_ready = 1'b1;

	bbc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Item moves to the result register when that register is free or drained
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{action: action, level: level, condition: condition,
				indicators: indicators};
		end
	end

	bbc_core #(
		.START_LEVEL (7'(START_BRIGHTNESS)),
		.START_ON_B  (1'(START_ON))
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res;
	end

	assign out_valid      = valid_s2;
	assign led_level      = res_s2.led_level;
	assign reported_level = res_s2.reported_level;
	assign is_on          = res_s2.is_on;
	assign save_request   = res_s2.save_request;
	assign status         = res_s2.status;

endmodule

`default_nettype wire
